[design/esud_pkg.sv]
`timescale 1ns / 1ps
// Package for the escape sequence decoder: parse modes, character codes,
// digit limits, queue entry layout and the UTF-8 encoder. No dependencies.
package esud_pkg;

    localparam int OCT_DIGIT_LIMIT = 22;
    localparam int HEX_DIGIT_LIMIT = 16;
    localparam int CNT_W           = 5;
    localparam int ENTRY_BYTES     = 5;
    localparam int ENTRY_CNT_W     = $clog2(ENTRY_BYTES + 1);
    localparam int QUEUE_DEPTH     = 2;
    localparam int QUEUE_AW        = $clog2(QUEUE_DEPTH);

    localparam logic [CNT_W-1:0] OCT_LIMIT = CNT_W'(OCT_DIGIT_LIMIT);
    localparam logic [CNT_W-1:0] HEX_LIMIT = CNT_W'(HEX_DIGIT_LIMIT);

    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_APOS      = 8'h27;
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_QUESTION  = 8'h3F;
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_SEVEN     = 8'h37;
    localparam logic [7:0] CH_NINE      = 8'h39;
    localparam logic [7:0] CH_UPPER_A   = 8'h41;
    localparam logic [7:0] CH_UPPER_F   = 8'h46;
    localparam logic [7:0] CH_LOWER_A   = 8'h61;
    localparam logic [7:0] CH_LOWER_B   = 8'h62;
    localparam logic [7:0] CH_LOWER_F   = 8'h66;
    localparam logic [7:0] CH_LOWER_N   = 8'h6E;
    localparam logic [7:0] CH_LOWER_R   = 8'h72;
    localparam logic [7:0] CH_LOWER_T   = 8'h74;
    localparam logic [7:0] CH_LOWER_U   = 8'h75;
    localparam logic [7:0] CH_LOWER_V   = 8'h76;
    localparam logic [7:0] CH_LOWER_X   = 8'h78;
    localparam logic [7:0] CASE_MASK    = 8'hDF;

    typedef enum logic [1:0] {
        MODE_TEXT = 2'd0,
        MODE_ESC  = 2'd1,
        MODE_OCT  = 2'd2,
        MODE_HEX  = 2'd3
    } mode_t;

    typedef struct packed {
        logic [3:0][7:0] b;
        logic [2:0]      n;
    } utf8_t;

    typedef struct packed {
        logic [ENTRY_BYTES-1:0][7:0] b;
        logic [ENTRY_CNT_W-1:0]      n;
    } entry_t;

    typedef struct packed {
        logic   push;
        entry_t data;
    } push_t;

    typedef struct packed {
        logic   valid;
        entry_t data;
    } head_t;

    function automatic utf8_t utf8_encode(input logic [31:0] v);
        utf8_t r;
        r.b = '0;
        r.n = 3'd0;
        if (v[31])
        begin
            r.n = 3'd0;
        end
        else if (v < 32'h80)
        begin
            r.b[0] = v[7:0];
            r.n    = 3'd1;
        end
        else if (v < 32'h800)
        begin
            r.b[0] = 8'hC0 | {3'b000, v[10:6]};
            r.b[1] = 8'h80 | {2'b00, v[5:0]};
            r.n    = 3'd2;
        end
        else if (v < 32'h10000)
        begin
            r.b[0] = 8'hE0 | {4'b0000, v[15:12]};
            r.b[1] = 8'h80 | {2'b00, v[11:6]};
            r.b[2] = 8'h80 | {2'b00, v[5:0]};
            r.n    = 3'd3;
        end
        else if (v < 32'h200000)
        begin
            r.b[0] = 8'hF0 | {5'b00000, v[20:18]};
            r.b[1] = 8'h80 | {2'b00, v[17:12]};
            r.b[2] = 8'h80 | {2'b00, v[11:6]};
            r.b[3] = 8'h80 | {2'b00, v[5:0]};
            r.n    = 3'd4;
        end
        return r;
    endfunction

    // Simple escapes: returns {hit, byte}.
    function automatic logic [8:0] simple_escape(input logic [7:0] c);
        logic [8:0] r;
        case (c)
            CH_LOWER_A:   r = {1'b1, 8'h07};
            CH_LOWER_B:   r = {1'b1, 8'h08};
            CH_LOWER_F:   r = {1'b1, 8'h0C};
            CH_LOWER_N:   r = {1'b1, 8'h0A};
            CH_LOWER_R:   r = {1'b1, 8'h0D};
            CH_LOWER_T:   r = {1'b1, 8'h09};
            CH_LOWER_V:   r = {1'b1, 8'h0B};
            CH_APOS:      r = {1'b1, c};
            CH_QUOTE:     r = {1'b1, c};
            CH_BACKSLASH: r = {1'b1, c};
            CH_QUESTION:  r = {1'b1, c};
            default:      r = {1'b0, 8'h00};
        endcase
        return r;
    endfunction

endpackage

[design/esud_front.sv]
`timescale 1ns / 1ps
// Front end: accepts characters, tracks the escape parse state and builds
// one queue entry of up to five output bytes per character. Uses esud_pkg.
module esud_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [7:0]          in_char,
    input  logic                in_last,
    input  logic                queue_full,
    output logic                in_ready,
    output esud_pkg::push_t     push
);

    esud_pkg::mode_t                 mode_reg, mode_next;
    logic [31:0]                     cv_reg, cv_next;
    logic [esud_pkg::CNT_W-1:0]      cnt_reg, cnt_next;

    logic                            accept;
    logic                            is_hex;
    logic                            is_oct_digit;
    logic                            is_digit;
    logic [3:0]                      digit;
    logic [7:0]                      upper_c;
    logic [31:0]                     cv_shift;
    logic [esud_pkg::CNT_W-1:0]      cnt_inc;
    logic                            limit_hit;
    logic                            esc_oct_hit;
    logic [8:0]                      simple;

    logic                            code_en;
    logic [31:0]                     code_val;
    logic [7:0]                      lit0, lit1;
    logic [1:0]                      nlit;
    logic                            plain;
    esud_pkg::utf8_t                 code;
    logic [2:0]                      code_n;

    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;

    // Character classification shared by both blocks below.
    always_comb
    begin
        is_hex       = (mode_reg == esud_pkg::MODE_HEX);
        upper_c      = in_char & esud_pkg::CASE_MASK;
        is_oct_digit = (in_char >= esud_pkg::CH_ZERO) && (in_char <= esud_pkg::CH_SEVEN);
        digit        = 4'd0;
        is_digit     = 1'b0;
        if (is_oct_digit || (is_hex && (in_char >= esud_pkg::CH_ZERO)
                                    && (in_char <= esud_pkg::CH_NINE)))
        begin
            digit    = 4'(in_char - esud_pkg::CH_ZERO);
            is_digit = 1'b1;
        end
        else if (is_hex && (upper_c >= esud_pkg::CH_UPPER_A)
                        && (upper_c <= esud_pkg::CH_UPPER_F))
        begin
            digit    = 4'(upper_c - esud_pkg::CH_UPPER_A + 8'd10);
            is_digit = 1'b1;
        end
        cv_shift    = is_hex ? {cv_reg[27:0], digit} : {cv_reg[28:0], digit[2:0]};
        cnt_inc     = cnt_reg + 1'b1;
        limit_hit   = cnt_inc >= (is_hex ? esud_pkg::HEX_LIMIT : esud_pkg::OCT_LIMIT);
        esc_oct_hit = esud_pkg::OCT_LIMIT <= esud_pkg::CNT_W'(1);
        simple      = esud_pkg::simple_escape(in_char);
    end

    // Next parse state.
    always_comb
    begin
        mode_next = mode_reg;
        cv_next   = cv_reg;
        cnt_next  = cnt_reg;
        plain     = 1'b0;
        case (mode_reg)
            esud_pkg::MODE_OCT, esud_pkg::MODE_HEX:
            begin
                if (is_digit)
                begin
                    if (limit_hit)
                    begin
                        mode_next = esud_pkg::MODE_TEXT;
                        cv_next   = '0;
                        cnt_next  = '0;
                    end
                    else
                    begin
                        cv_next  = cv_shift;
                        cnt_next = cnt_inc;
                    end
                end
                else if (in_char != esud_pkg::CH_APOS)
                begin
                    mode_next = esud_pkg::MODE_TEXT;
                    cv_next   = '0;
                    cnt_next  = '0;
                    plain     = 1'b1;
                end
            end
            esud_pkg::MODE_ESC:
            begin
                mode_next = esud_pkg::MODE_TEXT;
                if (!simple[8] && ((in_char == esud_pkg::CH_LOWER_X)
                                || (in_char == esud_pkg::CH_LOWER_U)))
                begin
                    mode_next = esud_pkg::MODE_HEX;
                    cv_next   = '0;
                    cnt_next  = '0;
                end
                else if (is_oct_digit && !esc_oct_hit)
                begin
                    mode_next = esud_pkg::MODE_OCT;
                    cv_next   = {29'd0, digit[2:0]};
                    cnt_next  = esud_pkg::CNT_W'(1);
                end
            end
            default:
            begin
                plain = 1'b1;
            end
        endcase
        if (plain && (in_char == esud_pkg::CH_BACKSLASH))
        begin
            mode_next = esud_pkg::MODE_ESC;
        end
    end

    // Output bytes: an optional code point, then up to two literal bytes.
    always_comb
    begin
        code_en  = 1'b0;
        code_val = cv_reg;
        lit0     = 8'h00;
        lit1     = 8'h00;
        nlit     = 2'd0;
        case (mode_reg)
            esud_pkg::MODE_OCT, esud_pkg::MODE_HEX:
            begin
                if (is_digit)
                begin
                    if (limit_hit)
                    begin
                        code_en  = 1'b1;
                        code_val = cv_shift;
                    end
                end
                else if (in_char != esud_pkg::CH_APOS)
                begin
                    code_en = 1'b1;
                end
            end
            esud_pkg::MODE_ESC:
            begin
                if (simple[8])
                begin
                    lit0 = simple[7:0];
                    nlit = 2'd1;
                end
                else if ((in_char == esud_pkg::CH_NEWLINE)
                      || (in_char == esud_pkg::CH_LOWER_X)
                      || (in_char == esud_pkg::CH_LOWER_U))
                begin
                    nlit = 2'd0;
                end
                else if (is_oct_digit)
                begin
                    code_en  = esc_oct_hit;
                    code_val = {29'd0, digit[2:0]};
                end
                else
                begin
                    lit0 = esud_pkg::CH_BACKSLASH;
                    lit1 = in_char;
                    nlit = 2'd2;
                end
            end
            default:
            begin
                nlit = 2'd0;
            end
        endcase
        if (plain && (in_char != esud_pkg::CH_BACKSLASH))
        begin
            lit0 = in_char;
            nlit = 2'd1;
        end
        if (in_last)
        begin
            if (mode_next == esud_pkg::MODE_ESC)
            begin
                // A trailing backslash stands for itself.
                lit0 = esud_pkg::CH_BACKSLASH;
                nlit = 2'd1;
            end
            else if ((mode_next == esud_pkg::MODE_OCT) || (mode_next == esud_pkg::MODE_HEX))
            begin
                code_en  = 1'b1;
                code_val = cv_next;
            end
        end
    end

    assign code   = esud_pkg::utf8_encode(code_val);
    assign code_n = code_en ? code.n : 3'd0;

    always_comb
    begin
        push.push   = 1'b0;
        push.data.b = '0;
        push.data.n = esud_pkg::ENTRY_CNT_W'(code_n) + esud_pkg::ENTRY_CNT_W'(nlit);
        for (int i = 0; i < esud_pkg::ENTRY_BYTES; i++)
        begin
            if (i < 4 && 3'(i) < code_n)
            begin
                push.data.b[i] = code.b[i[1:0]];
            end
            else if (3'(i) == code_n)
            begin
                push.data.b[i] = lit0;
            end
            else
            begin
                push.data.b[i] = lit1;
            end
        end
        push.push = accept && (push.data.n != '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= esud_pkg::MODE_TEXT;
            cv_reg   <= '0;
            cnt_reg  <= '0;
        end
        else if (accept)
        begin
            if (in_last)
            begin
                mode_reg <= esud_pkg::MODE_TEXT;
                cv_reg   <= '0;
                cnt_reg  <= '0;
            end
            else
            begin
                mode_reg <= mode_next;
                cv_reg   <= cv_next;
                cnt_reg  <= cnt_next;
            end
        end
    end

endmodule

[design/esud_queue.sv]
`timescale 1ns / 1ps
// Short queue of output entries between the front and back ends.
// Uses esud_pkg for the entry layout and depth.
module esud_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  esud_pkg::push_t  push,
    input  logic             pop,
    output logic             full,
    output esud_pkg::head_t  head
);

    esud_pkg::entry_t                 ram [esud_pkg::QUEUE_DEPTH];
    logic [esud_pkg::QUEUE_AW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [esud_pkg::QUEUE_AW:0]      count_reg, count_next;

    assign full       = count_reg == (esud_pkg::QUEUE_AW + 1)'(esud_pkg::QUEUE_DEPTH);
    assign head.valid = count_reg != '0;
    assign head.data  = ram[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push.push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push.push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.push)
        begin
            ram[wr_ptr_reg] <= push.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push.push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

`ifndef SYNTHESIS
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push.push |-> !full)
        else $error("queue pushed while full");
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head.valid)
        else $error("queue popped while empty");
    a_no_empty_entry: assert property (@(posedge clk) disable iff (!rst_n)
        push.push |-> (push.data.n != '0))
        else $error("entry without bytes pushed");
`endif

endmodule

[design/esud_back.sv]
`timescale 1ns / 1ps
// Back end: walks the bytes of the head queue entry onto the output stream
// and pops the entry after its last byte. Uses esud_pkg.
module esud_back (
    input  logic             clk,
    input  logic             rst_n,
    input  esud_pkg::head_t  head,
    input  logic             out_ready,
    output logic             out_valid,
    output logic [7:0]       out_byte,
    output logic             run_last,
    output logic             pop
);

    logic [esud_pkg::ENTRY_CNT_W-1:0] idx_reg, idx_next;

    assign out_valid = head.valid;
    assign out_byte  = head.data.b[idx_reg];
    assign run_last  = (idx_reg + 1'b1) == head.data.n;
    assign pop       = out_valid && out_ready && run_last;

    always_comb
    begin
        idx_next = idx_reg;
        if (out_valid && out_ready)
        begin
            idx_next = run_last ? '0 : idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
        end
        else
        begin
            idx_reg <= idx_next;
        end
    end

`ifndef SYNTHESIS
    a_idx_in_entry: assert property (@(posedge clk) disable iff (!rst_n)
        head.valid |-> (idx_reg < head.data.n))
        else $error("byte index beyond entry length");
`endif

endmodule

[design/escape_sequence_utf8_decoder.sv]
`timescale 1ns / 1ps
// Top level of the escape sequence decoder with UTF-8 output.
// Instantiates esud_front, esud_queue and esud_back; uses esud_pkg.
//
//   Channel  Dir  Handshake                    Payload
//   s_axis   in   s_axis_tvalid/s_axis_tready  tdata = in_char, tlast = in_last
//   m_axis   out  m_axis_tvalid/m_axis_tready  tdata = out_byte, tlast = run_last
//
// One input character is taken per cycle while the two-entry queue has room.
// Each character yields zero to five output bytes, sent one per cycle while
// m_axis_tready is high, so the output port sets the rate when characters expand.
// Reset (rst_n low) returns the parser to plain text and empties the queue.
// A stalled output only stops input once both queue entries are held.
module escape_sequence_utf8_decoder (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] in_char
    input  logic       s_axis_tlast,
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic       m_axis_tlast
);

    esud_pkg::push_t push;
    esud_pkg::head_t head;
    logic            queue_full;
    logic            pop;

    esud_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_char    (s_axis_tdata),
        .in_last    (s_axis_tlast),
        .queue_full (queue_full),
        .in_ready   (s_axis_tready),
        .push       (push)
    );

    esud_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .full  (queue_full),
        .head  (head)
    );

    esud_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .out_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_byte  (m_axis_tdata),
        .run_last  (m_axis_tlast),
        .pop       (pop)
    );

endmodule

[sim/escape_sequence_utf8_decoder_test.sv]
`timescale 1ns / 1ps
// Self-checking test for escape_sequence_utf8_decoder: directed and random string bodies,
// with expected bytes predicted by a small tracker class. Needs esud_pkg and the decoder RTL.
module escape_sequence_utf8_decoder_test;
    import esud_pkg::*;

    localparam int ITEM_TARGET  = 170;
    localparam int CYCLE_LIMIT  = 100000;
    localparam int DRAIN_CYCLES = 20;
    localparam int IDLE_PCT     = 14;

    typedef struct packed {
        logic [7:0] value;
        logic       run_end;
    } decoded_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } char_req_t;

    // Predicts the decoded bytes from the accepted characters and checks the output.
    class escape_decode_tracker;
        mode_t       mode;
        logic [31:0] code;
        logic [4:0]  digits;
        decoded_t    decoded_q[$];
        int          mismatches;

        function new();
            mode       = MODE_TEXT;
            code       = '0;
            digits     = '0;
            mismatches = 0;
        endfunction

        function int pending();
            return decoded_q.size();
        endfunction

        function void put(logic [7:0] b);
            decoded_t e;
            e.value   = b;
            e.run_end = 1'b0;
            decoded_q.push_back(e);
        endfunction

        // A code point is written as one to four UTF-8 bytes; anything past 21 bits is dropped.
        function void emit_code(logic [31:0] v);
            if (v[31])
                return;
            if (v < 32'h80)
                put(v[7:0]);
            else if (v < 32'h800)
            begin
                put({3'b110, v[10:6]});
                put({2'b10, v[5:0]});
            end
            else if (v < 32'h10000)
            begin
                put({4'b1110, v[15:12]});
                put({2'b10, v[11:6]});
                put({2'b10, v[5:0]});
            end
            else if (v < 32'h200000)
            begin
                put({5'b11110, v[20:18]});
                put({2'b10, v[17:12]});
                put({2'b10, v[11:6]});
                put({2'b10, v[5:0]});
            end
        endfunction

        function void end_number();
            emit_code(code);
            mode   = MODE_TEXT;
            code   = '0;
            digits = '0;
        endfunction

        function void after_backslash(logic [7:0] c);
            case (c)
                CH_LOWER_A: put(8'h07);
                CH_LOWER_B: put(8'h08);
                CH_LOWER_F: put(8'h0C);
                CH_LOWER_N: put(8'h0A);
                CH_LOWER_R: put(8'h0D);
                CH_LOWER_T: put(8'h09);
                CH_LOWER_V: put(8'h0B);
                CH_APOS, CH_QUOTE, CH_BACKSLASH, CH_QUESTION: put(c);
                CH_NEWLINE: ;
                CH_LOWER_X, CH_LOWER_U:
                begin
                    mode   = MODE_HEX;
                    code   = '0;
                    digits = '0;
                    return;
                end
                default:
                begin
                    if (c >= CH_ZERO && c <= CH_SEVEN)
                    begin
                        mode   = MODE_OCT;
                        code   = 32'(c - CH_ZERO);
                        digits = 5'd1;
                        if (digits >= OCT_LIMIT)
                            end_number();
                        return;
                    end
                    put(CH_BACKSLASH);
                    put(c);
                end
            endcase
            mode = MODE_TEXT;
        endfunction

        function void take_char(logic [7:0] c, logic is_end);
            int         first;
            logic       hex;
            logic       is_digit;
            logic       plain;
            logic [3:0] d;
            logic [7:0] up;
            first    = decoded_q.size();
            plain    = 1'b0;
            is_digit = 1'b0;
            d        = '0;
            if (mode == MODE_OCT || mode == MODE_HEX)
            begin
                hex = (mode == MODE_HEX);
                up  = c & CASE_MASK;
                if (c >= CH_ZERO && c <= (hex ? CH_NINE : CH_SEVEN))
                begin
                    d        = 4'(c - CH_ZERO);
                    is_digit = 1'b1;
                end
                else if (hex && up >= CH_UPPER_A && up <= CH_UPPER_F)
                begin
                    d        = 4'(up - CH_UPPER_A + 8'd10);
                    is_digit = 1'b1;
                end
                if (is_digit)
                begin
                    code   = hex ? {code[27:0], d} : {code[28:0], d[2:0]};
                    digits = digits + 5'd1;
                    if (digits >= (hex ? HEX_LIMIT : OCT_LIMIT))
                        end_number();
                end
                else if (c != CH_APOS)
                begin
                    // The byte that ends the number is handled as text right after it.
                    end_number();
                    plain = 1'b1;
                end
            end
            else if (mode == MODE_ESC)
                after_backslash(c);
            else
                plain = 1'b1;

            if (plain)
            begin
                if (c == CH_BACKSLASH)
                    mode = MODE_ESC;
                else
                    put(c);
            end

            if (is_end)
            begin
                if (mode == MODE_ESC)
                    put(CH_BACKSLASH);
                else if (mode == MODE_OCT || mode == MODE_HEX)
                    emit_code(code);
                mode   = MODE_TEXT;
                code   = '0;
                digits = '0;
            end

            if (decoded_q.size() > first)
                decoded_q[decoded_q.size() - 1].run_end = 1'b1;
        endfunction

        function void match_byte(logic [7:0] b, logic l);
            decoded_t want;
            if (decoded_q.size() == 0)
            begin
                $display("%0t: expected no byte, got %02h with tlast %0b", $time, b, l);
                mismatches++;
                return;
            end
            want = decoded_q.pop_front();
            if (want.value !== b)
            begin
                $display("%0t: out_byte expected %02h, got %02h", $time, want.value, b);
                mismatches++;
            end
            if (want.run_end !== l)
            begin
                $display("%0t: run_last expected %0b, got %0b", $time, want.run_end, l);
                mismatches++;
            end
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       s_axis_tvalid;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata;    // [7:0] in_char
    logic       s_axis_tlast;
    logic       m_axis_tvalid;
    logic       m_axis_tready;
    logic [7:0] m_axis_tdata;    // [7:0] out_byte
    logic       m_axis_tlast;

    escape_decode_tracker tracker;
    char_req_t            text_q[$];
    logic                 steady;
    int                   cycles = 0;

    logic [7:0] simple_set [12] = '{CH_LOWER_A, CH_LOWER_B, CH_LOWER_F, CH_LOWER_N,
                                    CH_LOWER_R, CH_LOWER_T, CH_LOWER_V, CH_APOS,
                                    CH_QUOTE, CH_BACKSLASH, CH_QUESTION, CH_NEWLINE};

    escape_sequence_utf8_decoder uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic void add_char(logic [7:0] c, logic l);
        char_req_t r;
        r.ch   = c;
        r.last = l;
        text_q.push_back(r);
    endfunction

    // Backslash, optional x/u, then digits with the odd separator and sometimes a random terminator.
    task automatic add_numeric(input logic hex);
        int         top;
        int         pick;
        int         ndig;
        int         v;
        logic [7:0] c;
        top  = hex ? HEX_DIGIT_LIMIT : OCT_DIGIT_LIMIT;
        pick = $urandom_range(0, 99);
        add_char(CH_BACKSLASH, 1'b0);
        if (hex)
            add_char($urandom_range(0, 1) ? CH_LOWER_X : CH_LOWER_U, 1'b0);
        if (pick < 10)
            ndig = hex ? 0 : 1;
        else if (pick < 65)
            ndig = $urandom_range(1, 5);
        else if (pick < 85)
            ndig = $urandom_range(1, top);
        else
            ndig = top;
        for (int i = 0; i < ndig; i++)
        begin
            if ((hex || i > 0) && $urandom_range(0, 9) == 0)
                add_char(CH_APOS, 1'b0);
            if (hex)
            begin
                v = $urandom_range(0, 15);
                if (v < 10)
                    c = CH_ZERO + 8'(v);
                else
                    c = ($urandom_range(0, 1) ? CH_UPPER_A : CH_LOWER_A) + 8'(v - 10);
            end
            else
                c = CH_ZERO + 8'($urandom_range(0, 7));
            add_char(c, 1'b0);
        end
        if ($urandom_range(0, 99) < 60)
            add_char(8'($urandom_range(0, 255)), 1'b0);
    endtask

    task automatic build_text();
        int         kind;
        logic [7:0] c;
        // Opening checks: byte extremes, a simple escape, escaped backslash and newline,
        // an unknown escape, hex with a separator, hex with no digits, octal cut by the
        // final byte, and a trailing backslash.
        add_char(8'h00, 1'b0);
        add_char(8'hFF, 1'b0);
        add_char(CH_BACKSLASH, 1'b0); add_char(CH_LOWER_A, 1'b0);
        add_char(CH_BACKSLASH, 1'b0); add_char(CH_BACKSLASH, 1'b0);
        add_char(CH_BACKSLASH, 1'b0); add_char(CH_NEWLINE, 1'b0);
        add_char(CH_BACKSLASH, 1'b0); add_char(8'h71, 1'b0);
        add_char(CH_BACKSLASH, 1'b0); add_char(CH_LOWER_X, 1'b0);
        add_char(8'h34, 1'b0); add_char(CH_APOS, 1'b0);
        add_char(8'h65, 1'b0); add_char(8'h67, 1'b0);
        add_char(CH_BACKSLASH, 1'b0); add_char(CH_LOWER_U, 1'b0); add_char(8'h7A, 1'b0);
        add_char(CH_BACKSLASH, 1'b0); add_char(CH_SEVEN, 1'b0);
        add_char(CH_SEVEN, 1'b0); add_char(CH_SEVEN, 1'b1);
        add_char(CH_BACKSLASH, 1'b1);

        while (text_q.size() < ITEM_TARGET)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 20)
            begin
                c = 8'($urandom_range(0, 255));
                if (c == CH_BACKSLASH)
                    c = c ^ 8'h01;
                add_char(c, 1'b0);
            end
            else if (kind < 40)
            begin
                add_char(CH_BACKSLASH, 1'b0);
                add_char(simple_set[$urandom_range(0, 11)], 1'b0);
            end
            else if (kind < 48)
            begin
                add_char(CH_BACKSLASH, 1'b0);
                add_char(8'($urandom_range(0, 255)), 1'b0);
            end
            else if (kind < 68)
                add_numeric(1'b1);
            else if (kind < 84)
                add_numeric(1'b0);
            else if (kind < 95)
                add_char(8'($urandom_range(0, 255)), 1'b0);
            else
                add_char(CH_BACKSLASH, 1'b1);
            if ($urandom_range(0, 99) < 15)
                text_q[text_q.size() - 1].last = 1'b1;
        end
    endtask

    task automatic send_text();
        int sent;
        int hold_at;
        sent    = 0;
        hold_at = text_q.size() / 2;
        while (sent < text_q.size())
        begin
            @(negedge clk);
            steady = (sent >= 70 && sent < 110);
            if (sent == hold_at)
            begin
                // Hold the next request back until the decoder has delivered everything.
                s_axis_tvalid <= 1'b0;
                hold_at = -1;
                do
                    @(negedge clk);
                while (tracker.pending() != 0);
            end
            if (!steady && $urandom_range(0, 99) < IDLE_PCT)
            begin
                s_axis_tvalid <= 1'b0;
                continue;
            end
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= text_q[sent].ch;
            s_axis_tlast  <= text_q[sent].last;
            do
                @(posedge clk);
            while (!s_axis_tready);
            tracker.take_char(text_q[sent].ch, text_q[sent].last);
            sent++;
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        steady = 1'b0;
    endtask

    always @(negedge clk)
        if (rst_n)
            m_axis_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);

    always @(posedge clk)
        if (rst_n && m_axis_tvalid && m_axis_tready)
            tracker.match_byte(m_axis_tdata, m_axis_tlast);

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin
        clk           = 1'b0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        m_axis_tready = 1'b0;
        steady        = 1'b0;
        tracker       = new();
        build_text();
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        send_text();
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (tracker.mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
